@@ design/phsqp_pkg.sv @@
// phsqp_pkg: shared types and fixed constants of the point hash set.
// No dependencies; used by every module of the block.
`default_nettype none

package phsqp_pkg;

    localparam int HASH_X_OFS  = 79;
    localparam int HASH_Y_OFS  = 37;
    localparam int HASH_MUL    = 19;
    localparam int HASH_ADD    = 102793;

    localparam int ENTRY_W     = 9;
    localparam int MOD_DIGIT   = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_RESP
    } back_state_t;

    typedef struct packed {
        logic found;
        logic stored;
        logic full;
    } res_flags_t;

endpackage

`default_nettype wire

@@ design/phsqp_fifo.sv @@
// phsqp_fifo: short request queue between the hash front and the probe back.
// Depends on phsqp_pkg for the queue depth.
`default_nettype none

module phsqp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(phsqp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(phsqp_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] data_reg [phsqp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == CNT_W'(phsqp_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/phsqp_front.sv @@
// phsqp_front: takes requests and computes the home slot of each point.
// Two multiply stages, then a radix-16 restoring reduction. Uses phsqp_pkg.
`default_nettype none

module phsqp_front #(
    parameter int TABLE_SLOTS = 503,
    parameter int COORD_BITS  = 12,
    parameter int SLOT_W      = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  hold,
    input  logic                  op,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    output logic                  push,
    input  logic                  push_full,
    output logic                  q_op,
    output logic [COORD_BITS-1:0] q_x,
    output logic [COORD_BITS-1:0] q_y,
    output logic [SLOT_W-1:0]     q_home
);

    localparam int XA_W = $clog2((2 ** COORD_BITS) + phsqp_pkg::HASH_X_OFS);
    localparam int YA_W = $clog2((2 ** COORD_BITS) + phsqp_pkg::HASH_Y_OFS);
    localparam int P1_W = XA_W + YA_W;
    localparam longint unsigned HASH_MAX =
        (longint'((2 ** COORD_BITS) - 1) + phsqp_pkg::HASH_X_OFS)
        * (longint'((2 ** COORD_BITS) - 1) + phsqp_pkg::HASH_Y_OFS)
        * phsqp_pkg::HASH_MUL + phsqp_pkg::HASH_ADD;
    localparam int HASH_W    = $clog2(HASH_MAX + 1);
    localparam int MOD_STEPS = (HASH_W + phsqp_pkg::MOD_DIGIT - 1) / phsqp_pkg::MOD_DIGIT;
    localparam int MOD_W     = MOD_STEPS * phsqp_pkg::MOD_DIGIT;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(TABLE_SLOTS);

    phsqp_pkg::front_state_t state_reg;
    phsqp_pkg::front_state_t state_next;

    logic                  accept;
    logic                  op_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [XA_W-1:0]       xa;
    logic [YA_W-1:0]       ya;
    logic [P1_W-1:0]       prod_reg;
    logic [MOD_W-1:0]      hv_reg;
    logic [SLOT_W-1:0]     rem_reg;
    logic [SLOT_W-1:0]     rem_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  last_step;

    assign xa        = XA_W'(coord_x) + XA_W'(phsqp_pkg::HASH_X_OFS);
    assign ya        = YA_W'(coord_y) + YA_W'(phsqp_pkg::HASH_Y_OFS);
    assign last_step = (step_reg == STEP_W'(MOD_STEPS - 1));

    // one remainder digit per cycle
    always_comb
    begin
        logic [SLOT_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < phsqp_pkg::MOD_DIGIT; i++)
        begin
            r = {r[SLOT_W-1:0], hv_reg[MOD_W-1-i]};
            if (r >= SLOTS_X)
            begin
                r = r - SLOTS_X;
            end
        end
        rem_next = r[SLOT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phsqp_pkg::F_IDLE:
            begin
                if (in_valid && !hold)
                begin
                    state_next = phsqp_pkg::F_MUL;
                end
            end
            phsqp_pkg::F_MUL:
            begin
                state_next = phsqp_pkg::F_MOD;
            end
            phsqp_pkg::F_MOD:
            begin
                if (last_step)
                begin
                    state_next = phsqp_pkg::F_PUSH;
                end
            end
            phsqp_pkg::F_PUSH:
            begin
                if (!push_full)
                begin
                    state_next = phsqp_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = phsqp_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != phsqp_pkg::F_IDLE) || hold;
        accept   = (state_reg == phsqp_pkg::F_IDLE) && in_valid && !hold;
        push     = (state_reg == phsqp_pkg::F_PUSH) && !push_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phsqp_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            x_reg    <= coord_x;
            y_reg    <= coord_y;
            prod_reg <= P1_W'(xa) * P1_W'(ya);
        end
        if (state_reg == phsqp_pkg::F_MUL)
        begin
            hv_reg   <= MOD_W'(prod_reg) * MOD_W'(phsqp_pkg::HASH_MUL)
                        + MOD_W'(phsqp_pkg::HASH_ADD);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == phsqp_pkg::F_MOD)
        begin
            hv_reg   <= hv_reg << phsqp_pkg::MOD_DIGIT;
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign q_op   = op_reg;
    assign q_x    = x_reg;
    assign q_y    = y_reg;
    assign q_home = rem_reg;

endmodule

`default_nettype wire

@@ design/phsqp_back.sv @@
// phsqp_back: probes the slot memory quadratically and answers each request.
// Holds the slot memory, the stored count and the result register. Uses phsqp_pkg.
`default_nettype none

module phsqp_back #(
    parameter int TABLE_SLOTS = 503,
    parameter int COORD_BITS  = 12,
    parameter int SLOT_W      = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    output logic                           pop,
    input  logic                           q_op,
    input  logic [COORD_BITS-1:0]          q_x,
    input  logic [COORD_BITS-1:0]          q_y,
    input  logic [SLOT_W-1:0]              q_home,
    output logic                           clearing,
    output logic                           out_valid,
    input  logic                           out_stall,
    output phsqp_pkg::res_flags_t          out_flags,
    output logic [phsqp_pkg::ENTRY_W-1:0]  out_count
);

    localparam int ENT_W = 1 + 2 * COORD_BITS;
    localparam int K_W   = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W = $clog2(TABLE_SLOTS / 2 + 2);
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(TABLE_SLOTS);

    phsqp_pkg::back_state_t state_reg;
    phsqp_pkg::back_state_t state_next;

    logic [ENT_W-1:0]      mem [TABLE_SLOTS];
    logic [ENT_W-1:0]      rd_data_reg;
    logic                  mem_we;
    logic [SLOT_W-1:0]     wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic [SLOT_W-1:0]     clear_idx_reg;
    logic                  clear_last;
    logic                  op_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [SLOT_W-1:0]     inc_reg;
    logic [SLOT_W-1:0]     inc_next;
    logic [K_W-1:0]        k_reg;
    logic [CNT_W-1:0]      count_reg;

    logic                  rd_valid;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic                  hit;
    logic                  last_probe;
    logic                  done;
    logic                  can_store;
    logic                  out_free;
    logic                  load_out;

    phsqp_pkg::res_flags_t res_reg;
    phsqp_pkg::res_flags_t out_flags_reg;
    logic [phsqp_pkg::ENTRY_W-1:0] out_count_reg;
    logic                  out_valid_reg;

    assign rd_valid   = rd_data_reg[ENT_W-1];
    assign rd_x       = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_y       = rd_data_reg[COORD_BITS-1:0];
    assign hit        = rd_valid && (rd_x == x_reg) && (rd_y == y_reg);
    assign last_probe = (k_reg == K_W'(TABLE_SLOTS - 1));
    assign done       = hit || !rd_valid || last_probe;
    assign can_store  = op_reg && !rd_valid && (count_reg <= CNT_W'(TABLE_SLOTS / 2));
    assign clear_last = (clear_idx_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign out_free   = !out_valid_reg || !out_stall;

    // offsets k^2 by running sums of odd steps, all kept below the table size
    always_comb
    begin
        logic [SLOT_W:0] s;
        logic [SLOT_W:0] d;
        s = {1'b0, slot_reg} + {1'b0, inc_reg};
        if (s >= SLOTS_X)
        begin
            s = s - SLOTS_X;
        end
        d = {1'b0, inc_reg} + (SLOT_W + 1)'(2);
        if (d >= SLOTS_X)
        begin
            d = d - SLOTS_X;
        end
        slot_next = s[SLOT_W-1:0];
        inc_next  = d[SLOT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phsqp_pkg::B_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = phsqp_pkg::B_IDLE;
                end
            end
            phsqp_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = phsqp_pkg::B_READ;
                end
            end
            phsqp_pkg::B_READ:
            begin
                state_next = phsqp_pkg::B_CHECK;
            end
            phsqp_pkg::B_CHECK:
            begin
                if (done)
                begin
                    state_next = phsqp_pkg::B_RESP;
                end
                else
                begin
                    state_next = phsqp_pkg::B_READ;
                end
            end
            phsqp_pkg::B_RESP:
            begin
                if (out_free)
                begin
                    state_next = phsqp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = phsqp_pkg::B_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clearing = (state_reg == phsqp_pkg::B_CLEAR);
        pop      = (state_reg == phsqp_pkg::B_IDLE) && !q_empty;
        load_out = (state_reg == phsqp_pkg::B_RESP) && out_free;
        mem_we   = clearing || ((state_reg == phsqp_pkg::B_CHECK) && can_store);
        wr_addr  = clearing ? clear_idx_reg : slot_reg;
        wr_data  = clearing ? '0 : {1'b1, x_reg, y_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phsqp_pkg::B_CLEAR;
            clear_idx_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clear_idx_reg <= clear_idx_reg + SLOT_W'(1);
            end
            if ((state_reg == phsqp_pkg::B_CHECK) && can_store)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= q_op;
            x_reg    <= q_x;
            y_reg    <= q_y;
            slot_reg <= q_home;
            inc_reg  <= SLOT_W'(1);
            k_reg    <= '0;
        end
        if ((state_reg == phsqp_pkg::B_CHECK) && !done)
        begin
            slot_reg <= slot_next;
            inc_reg  <= inc_next;
            k_reg    <= k_reg + K_W'(1);
        end
        if ((state_reg == phsqp_pkg::B_CHECK) && done)
        begin
            res_reg.found  <= hit;
            res_reg.stored <= can_store;
            res_reg.full   <= op_reg && !hit && !can_store;
        end
        if (load_out)
        begin
            out_flags_reg <= res_reg;
            out_count_reg <= phsqp_pkg::ENTRY_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flags = out_flags_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

@@ design/point_hash_set_quadratic_probe.sv @@
// point_hash_set_quadratic_probe: top level of the point hash set.
// Instantiates phsqp_front, phsqp_fifo and phsqp_back; types from phsqp_pkg.
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+-----------------------------------------
//  request | in_valid  | in_stall   | op, coord_x, coord_y
//  result  | out_valid | out_stall  | found, stored, full_res, entry_count
//
// Front: takes a request only when idle, multiplies, reduces, then pushes
// the home slot; it takes no new request until that push. Back: each probe
// reads then checks a slot; the slower side sets the sustained rate. After
// reset a clearing pass over all TABLE_SLOTS slots runs first; requests
// stall until it ends. Each side stalls on its own through a two-entry
// queue; a pending result does not block hashing of the next one.
`default_nettype none

module point_hash_set_quadratic_probe #(
    parameter int TABLE_SLOTS = 503,
    parameter int COORD_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [COORD_BITS-1:0]         coord_x,
    input  logic [COORD_BITS-1:0]         coord_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic                          stored,
    output logic                          full_res,
    output logic [phsqp_pkg::ENTRY_W-1:0] entry_count
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int Q_W    = 1 + 2 * COORD_BITS + SLOT_W;

    logic                  push;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    logic                  clearing;
    logic                  f_op;
    logic [COORD_BITS-1:0] f_x;
    logic [COORD_BITS-1:0] f_y;
    logic [SLOT_W-1:0]     f_home;
    logic                  b_op;
    logic [COORD_BITS-1:0] b_x;
    logic [COORD_BITS-1:0] b_y;
    logic [SLOT_W-1:0]     b_home;
    logic [Q_W-1:0]        q_in;
    logic [Q_W-1:0]        q_out;
    phsqp_pkg::res_flags_t flags;

    phsqp_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COORD_BITS  (COORD_BITS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hold      (clearing),
        .op        (op),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .push      (push),
        .push_full (q_full),
        .q_op      (f_op),
        .q_x       (f_x),
        .q_y       (f_y),
        .q_home    (f_home)
    );

    assign q_in = {f_op, f_x, f_y, f_home};

    phsqp_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {b_op, b_x, b_y, b_home} = q_out;

    phsqp_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COORD_BITS  (COORD_BITS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .q_op      (b_op),
        .q_x       (b_x),
        .q_y       (b_y),
        .q_home    (b_home),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_flags (flags),
        .out_count (entry_count)
    );

    assign found    = flags.found;
    assign stored   = flags.stored;
    assign full_res = flags.full;

endmodule

`default_nettype wire
